// File: rtl/core/mmde_pkg.sv
`default_nettype none
package mmde_pkg;

   // Largest matrix dimension held in the element stores
   localparam int MAX_DIM = 16;

   // Field widths of the streaming items
   localparam int MODE_W    = 2;
   localparam int ROW_W     = 4;
   localparam int COL_W     = 4;
   localparam int VALUE_W   = 16;
   localparam int PRODUCT_W = 36;
   localparam int CFG_W     = 5;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_TDATA_W = ROW_W + COL_W + VALUE_W;
   localparam int RSP_TDATA_W = ((PRODUCT_W + 7) / 8) * 8;
   localparam int MULT_W      = 2 * VALUE_W;

   // Store geometry, element (r, c) lives at r * MAX_DIM + c
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int SIZE_W  = (CFG_W > $clog2(MAX_DIM + 1)) ? CFG_W : $clog2(MAX_DIM + 1);

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   // Item kinds
   localparam logic [MODE_W-1:0] MODE_WRITE_A = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE_B = 2'd1;
   localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

   // Size register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_OF_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_OF_B    = 2'd2;

   typedef struct packed {
      logic clear;
      logic accumulate;
   } mac_ctl_type;

   function automatic logic [ADDR_W-1:0] elem_addr(input logic [ADDR_W-1:0] r,
                                                   input logic [ADDR_W-1:0] c);
      elem_addr = ADDR_W'(r * ADDR_W'(MAX_DIM)) + c;
   endfunction

   // Sizes above MAX_DIM act as MAX_DIM
   function automatic logic [SIZE_W-1:0] sat_size(input logic [CFG_W-1:0] r);
      sat_size = (SIZE_W'(r) > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : SIZE_W'(r);
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/mmde_ram.sv
`default_nettype none
module mmde_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/mmde_mac.sv
`default_nettype none
module mmde_mac (
   input  wire logic                                clock,
   input  wire mmde_pkg::mac_ctl_type               ctl,
   input  wire logic signed [mmde_pkg::VALUE_W-1:0] a_value,
   input  wire logic signed [mmde_pkg::VALUE_W-1:0] b_value,
   output logic signed [mmde_pkg::PRODUCT_W-1:0]    acc
);
   import mmde_pkg::*;

   logic signed [MULT_W-1:0]    prod;
   logic signed [PRODUCT_W-1:0] acc_ff;
   logic signed [PRODUCT_W-1:0] acc_in;

   assign prod = a_value * b_value;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.accumulate) begin
         acc_in = acc_ff + PRODUCT_W'(prod);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

// File: rtl/core/matrix_multiply_dot_engine_top.sv
// Dense matrix multiply engine, C = A x B, one element per transaction.
// req_ channel: tuser carries the kind (write A, write B, compute C), tdata
// carries row, col and the Q8.8 value. Writes land in the A or B store in
// the accept cycle. A compute walks the inner dimension with one shared
// multiply-accumulate unit, one inner element per cycle, reading A and B
// from two 256-entry stores with registered read ports.
// rsp_ channel: tdata carries the Q20.16 product (zero for writes and on
// error), tuser carries index_error. Every transaction gives one response.
// csr_ channel: writes the three size registers; ready is always high.
// Write them only while the engine is idle.
// A write, a rejected item or an empty inner dimension goes from accept
// straight to S_RESULT; a compute walks S_RUN over the inner dimension
// through the single multiplier, then S_LAST, then S_RESULT, which loads
// the response register. req_tready returns as the response loads, so one
// item is in flight and no new item is taken until that response loads.
// A finished response sits in the output register; the next item is
// accepted while it waits, and a new response holds until rsp_tready frees
// the register. Reset clears control and sets all sizes to 16; store
// contents are undefined until written.
`default_nettype none
module matrix_multiply_dot_engine_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [mmde_pkg::REQ_TDATA_W-1:0]      req_tdata,  // row, col, value
   input  wire logic [mmde_pkg::MODE_W-1:0]           req_tuser,  // mode
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic      [mmde_pkg::RSP_TDATA_W-1:0]      rsp_tdata,  // product
   output logic                                       rsp_tuser,  // index_error
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [mmde_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [mmde_pkg::CFG_W-1:0]            csr_data
);
   import mmde_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_LAST,
      S_RESULT
   } state_type;

   state_type                   state_ff, state_in;
   logic [IDX_W-1:0]            k_ff, k_in;
   logic [IDX_W-1:0]            k_last_ff, k_last_in;
   logic [ROW_W-1:0]            row_ff, row_in;
   logic [COL_W-1:0]            col_ff, col_in;
   logic                        err_ff, err_in;
   logic                        is_comp_ff, is_comp_in;
   logic                        rd_valid_ff, rd_valid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [PRODUCT_W-1:0] rsp_product_ff, rsp_product_in;
   logic                        rsp_err_ff, rsp_err_in;
   logic [CFG_W-1:0]            rows_ff, rows_in;
   logic [CFG_W-1:0]            inner_ff, inner_in;
   logic [CFG_W-1:0]            cols_ff, cols_in;

   // Request fields
   logic [MODE_W-1:0]           req_mode;
   logic [ROW_W-1:0]            req_row;
   logic [COL_W-1:0]            req_col;
   logic [VALUE_W-1:0]          req_value;
   logic                        req_accept;

   logic [SIZE_W-1:0]           ra_eff, ki_eff, cb_eff;
   logic                        a_ok, b_ok, c_ok;

   logic                        a_wr_en, b_wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [ADDR_W-1:0]           a_rd_addr, b_rd_addr;
   logic [VALUE_W-1:0]          a_rd_data, b_rd_data;

   mac_ctl_type                 mac_ctl;
   logic signed [PRODUCT_W-1:0] acc;

   assign req_mode  = req_tuser;
   assign req_row   = req_tdata[ROW_W-1:0];
   assign req_col   = req_tdata[ROW_W+COL_W-1:ROW_W];
   assign req_value = req_tdata[REQ_TDATA_W-1:ROW_W+COL_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign ra_eff = sat_size(rows_ff);
   assign ki_eff = sat_size(inner_ff);
   assign cb_eff = sat_size(cols_ff);

   // Range checks per kind
   assign a_ok = (SIZE_W'(req_row) < ra_eff) && (SIZE_W'(req_col) < ki_eff);
   assign b_ok = (SIZE_W'(req_row) < ki_eff) && (SIZE_W'(req_col) < cb_eff);
   assign c_ok = (SIZE_W'(req_row) < ra_eff) && (SIZE_W'(req_col) < cb_eff);

   // Writes commit straight from the request in the accept cycle
   assign wr_addr = elem_addr(ADDR_W'(req_row), ADDR_W'(req_col));
   assign a_wr_en = req_accept && (req_mode == MODE_WRITE_A) && a_ok;
   assign b_wr_en = req_accept && (req_mode == MODE_WRITE_B) && b_ok;

   // Walk row of A and column of B together
   assign a_rd_addr = elem_addr(ADDR_W'(row_ff), ADDR_W'(k_ff));
   assign b_rd_addr = elem_addr(ADDR_W'(k_ff), ADDR_W'(col_ff));

   mmde_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   mmde_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   mmde_mac u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .a_value ($signed(a_rd_data)),
      .b_value ($signed(b_rd_data)),
      .acc     (acc)
   );

   always_comb begin
      state_in       = state_ff;
      k_in           = k_ff;
      k_last_in      = k_last_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      err_in         = err_ff;
      is_comp_in     = is_comp_ff;
      rd_valid_in    = 1'b0;
      rsp_valid_in   = rsp_valid_ff;
      rsp_product_in = rsp_product_ff;
      rsp_err_in     = rsp_err_ff;
      rows_in        = rows_ff;
      inner_in       = inner_ff;
      cols_in        = cols_ff;

      // Read data from the stores is valid in the cycle after the address
      mac_ctl.clear      = 1'b0;
      mac_ctl.accumulate = rd_valid_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_ROWS_OF_A:    rows_in  = csr_data;
            REG_INNER_LENGTH: inner_in = csr_data;
            REG_COLS_OF_B:    cols_in  = csr_data;
            default: ;
         endcase
      end

      // Drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               row_in        = req_row;
               col_in        = req_col;
               k_in          = '0;
               k_last_in     = IDX_W'(ki_eff - SIZE_W'(1));
               mac_ctl.clear = 1'b1;
               is_comp_in    = 1'b0;
               err_in        = 1'b1;
               state_in      = S_RESULT;
               case (req_mode)
                  MODE_WRITE_A: err_in = !a_ok;
                  MODE_WRITE_B: err_in = !b_ok;
                  MODE_COMPUTE: begin
                     if (c_ok) begin
                        err_in     = 1'b0;
                        is_comp_in = 1'b1;
                        // An empty inner dimension answers with the cleared sum
                        if (ki_eff != '0) begin
                           state_in = S_RUN;
                        end
                     end
                  end
                  default: err_in = 1'b1;
               endcase
            end
         end
         S_RUN: begin
            rd_valid_in = 1'b1;
            if (k_ff == k_last_ff) begin
               state_in = S_LAST;
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         S_LAST: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_product_in = is_comp_ff ? acc : '0;
               rsp_err_in     = err_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= CFG_RESET;
         inner_ff     <= CFG_RESET;
         cols_ff      <= CFG_RESET;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rows_ff      <= rows_in;
         inner_ff     <= inner_in;
         cols_ff      <= cols_in;
      end
      k_ff           <= k_in;
      k_last_ff      <= k_last_in;
      row_ff         <= row_in;
      col_ff         <= col_in;
      err_ff         <= err_in;
      is_comp_ff     <= is_comp_in;
      rsp_product_ff <= rsp_product_in;
      rsp_err_ff     <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - PRODUCT_W){1'b0}}, rsp_product_ff};
   assign rsp_tuser  = rsp_err_ff;

`ifndef SYNTH
   a_err_zero_product: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_product_ff == '0)
      else $error("error response carries a nonzero product");

   a_k_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> k_ff <= k_last_ff)
      else $error("inner index ran past the inner length");

   a_mac_only_in_walk: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == S_RUN || state_ff == S_LAST))
      else $error("accumulate outside the inner walk");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction accepted while one is in flight");
`endif

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import mmde_pkg::*;

   // Codes the block has no name for: the spare item kind and register slot
   localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED  = 2'd3;

   localparam int NUM_SETTINGS      = 10;
   localparam int ITEMS_PER_SETTING = 180;

   // One expected response: product and the out-of-range flag
   typedef struct packed {
      logic [PRODUCT_W-1:0] product;
      logic                 index_error;
   } response_type;

   // Tracks the size registers and both element stores, works out the
   // response of every accepted request and checks responses in order.
   class dot_engine_model_type;
      logic [VALUE_W-1:0] a_elem [DEPTH];
      logic [VALUE_W-1:0] b_elem [DEPTH];
      bit                 a_loaded [DEPTH];
      bit                 b_loaded [DEPTH];
      logic [CFG_W-1:0]   size_reg [3];
      response_type       awaiting_products [$];
      int                 errors;

      function new();
         foreach (a_elem[i]) begin
            a_elem[i]   = '0;
            b_elem[i]   = '0;
            a_loaded[i] = 1'b0;
            b_loaded[i] = 1'b0;
         end
         foreach (size_reg[i]) size_reg[i] = CFG_RESET;
         errors = 0;
      endfunction

      // Size in effect: anything above the store size acts as the store size
      function int dim(int which);
         return (size_reg[which] > MAX_DIM) ? MAX_DIM : int'(size_reg[which]);
      endfunction

      function int pending();
         return awaiting_products.size();
      endfunction

      function void note_config(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         case (idx)
            REG_ROWS_OF_A, REG_INNER_LENGTH, REG_COLS_OF_B: size_reg[idx] = data;
            default: ;
         endcase
      endfunction

      function void note_request(logic [MODE_W-1:0] mode, logic [ROW_W-1:0] row,
                                 logic [COL_W-1:0] col, logic [VALUE_W-1:0] value);
         int                            ra, ki, cb, k;
         response_type                  rsp;
         logic signed [PRODUCT_W-1:0]   acc;
         logic signed [MULT_W-1:0]      term;
         ra  = dim(REG_ROWS_OF_A);
         ki  = dim(REG_INNER_LENGTH);
         cb  = dim(REG_COLS_OF_B);
         rsp = '0;
         case (mode)
            MODE_WRITE_A: begin
               if (row < ra && col < ki) begin
                  a_elem[row * MAX_DIM + col]   = value;
                  a_loaded[row * MAX_DIM + col] = 1'b1;
               end else begin
                  rsp.index_error = 1'b1;
               end
            end
            MODE_WRITE_B: begin
               if (row < ki && col < cb) begin
                  b_elem[row * MAX_DIM + col]   = value;
                  b_loaded[row * MAX_DIM + col] = 1'b1;
               end else begin
                  rsp.index_error = 1'b1;
               end
            end
            MODE_COMPUTE: begin
               if (row < ra && col < cb) begin
                  acc = '0;
                  for (k = 0; k < ki; k++) begin
                     term = $signed(a_elem[row * MAX_DIM + k]) *
                            $signed(b_elem[k * MAX_DIM + col]);
                     acc  = acc + term;
                  end
                  rsp.product = acc;
               end else begin
                  rsp.index_error = 1'b1;
               end
            end
            default: rsp.index_error = 1'b1;
         endcase
         awaiting_products = {awaiting_products, rsp};
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task check_response(logic [PRODUCT_W-1:0] product, logic index_error);
         response_type want;
         if (awaiting_products.size() == 0) begin
            report($sformatf("response product=%0d error=%b with no request outstanding",
                             $signed(product), index_error));
            return;
         end
         want = awaiting_products.pop_front();
         if (product !== want.product)
            report($sformatf("product %0d, expected %0d",
                             $signed(product), $signed(want.product)));
         if (index_error !== want.index_error)
            report($sformatf("index_error %b, expected %b", index_error, want.index_error));
      endtask
   endclass

   dot_engine_model_type model = new();

   // Clock and every block input start at a known value
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]      req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CFG_W-1:0]       csr_data   = '0;

   // Idle odds out of a hundred for the request and response sides
   int send_idle = 23;
   int recv_idle = 63;

   // Size settings walked by the random part: zero, one, full, above full
   logic [CFG_W-1:0] rows_list  [NUM_SETTINGS] = '{5'd16, 5'd1, 5'd4, 5'd0, 5'd31,
                                                   5'd16, 5'd16, 5'd17, 5'd16, 5'd3};
   logic [CFG_W-1:0] inner_list [NUM_SETTINGS] = '{5'd16, 5'd1, 5'd3, 5'd16, 5'd31,
                                                   5'd0, 5'd16, 5'd16, 5'd1, 5'd8};
   logic [CFG_W-1:0] cols_list  [NUM_SETTINGS] = '{5'd16, 5'd1, 5'd5, 5'd16, 5'd31,
                                                   5'd16, 5'd0, 5'd2, 5'd16, 5'd12};

   matrix_multiply_dot_engine_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // row, col, value
      .req_tuser  (req_tuser),   // mode
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // product
      .rsp_tuser  (rsp_tuser),   // index_error
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Throttle the response side; the odds change with the phase
   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle);

   // Check every response transaction against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         model.check_response(rsp_tdata[PRODUCT_W-1:0], rsp_tuser);
   end

   // Present one request, idling first at random; hold it until accepted.
   // Leave valid high on return so back-to-back requests need no toggle.
   task automatic send_item(logic [MODE_W-1:0] mode, logic [ROW_W-1:0] row,
                            logic [COL_W-1:0] col, logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_TDATA_W'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {value, col, row};
      do @(posedge clock); while (!req_tready);
      model.note_request(mode, row, col, value);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      model.note_config(idx, data);
      @(negedge clock);
   endtask

   // Drain the engine, then load all three sizes plus the spare slot
   task automatic apply_sizes(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] inner,
                              logic [CFG_W-1:0] cols);
      req_tvalid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
      @(negedge clock);
      write_csr(REG_ROWS_OF_A, rows);
      write_csr(REG_INNER_LENGTH, inner);
      write_csr(REG_COLS_OF_B, cols);
      write_csr(REG_UNUSED, CFG_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Mostly in-range writes and computes. A compute whose row of A or column
   // of B is not fully loaded yet turns into a write of the first missing
   // element, so the stores fill up and computes never read unwritten data.
   task automatic random_item();
      int                 pick, ra, ki, cb, k;
      logic [MODE_W-1:0]  mode;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic [VALUE_W-1:0] value;
      ra   = model.dim(REG_ROWS_OF_A);
      ki   = model.dim(REG_INNER_LENGTH);
      cb   = model.dim(REG_COLS_OF_B);
      pick = $urandom_range(99);
      row  = ROW_W'($urandom_range(15));
      col  = COL_W'($urandom_range(15));
      case ($urandom_range(7))
         0:       value = 16'h8000;
         1:       value = 16'h7FFF;
         default: value = VALUE_W'($urandom);
      endcase
      if (pick < 40) begin
         mode = MODE_WRITE_A;
         if (ra > 0 && ki > 0 && $urandom_range(9) != 0) begin
            row = ROW_W'($urandom_range(ra - 1));
            col = COL_W'($urandom_range(ki - 1));
         end
      end else if (pick < 80) begin
         mode = MODE_WRITE_B;
         if (ki > 0 && cb > 0 && $urandom_range(9) != 0) begin
            row = ROW_W'($urandom_range(ki - 1));
            col = COL_W'($urandom_range(cb - 1));
         end
      end else if (pick < 93) begin
         mode = MODE_COMPUTE;
         if (ra > 0 && cb > 0 && $urandom_range(9) != 0) begin
            row = ROW_W'($urandom_range(ra - 1));
            col = COL_W'($urandom_range(cb - 1));
         end
         if (row < ra && col < cb) begin
            for (k = 0; k < ki; k++) begin
               if (!model.a_loaded[row * MAX_DIM + k]) begin
                  mode = MODE_WRITE_A;
                  col  = COL_W'(k);
                  break;
               end
               if (!model.b_loaded[k * MAX_DIM + col]) begin
                  mode = MODE_WRITE_B;
                  row  = ROW_W'(k);
                  break;
               end
            end
         end
      end else begin
         // Noise: the spare kind, or writes anywhere in the index space
         mode = ($urandom_range(1) == 0) ? MODE_UNUSED :
                (($urandom_range(1) == 0) ? MODE_WRITE_A : MODE_WRITE_B);
      end
      send_item(mode, row, col, value);
   endtask

   initial begin
      // Hold reset, then release it on a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset sizes: the far corner is in range, the spare kind is rejected
      send_item(MODE_WRITE_A, 4'd15, 4'd15, 16'h5A5A);
      send_item(MODE_WRITE_B, 4'd15, 4'd15, 16'hA5A5);
      send_item(MODE_UNUSED, 4'd15, 4'd15, 16'hFFFF);

      // 2x2 by 2x2 with the most negative and most positive Q8.8 values
      apply_sizes(5'd2, 5'd2, 5'd2);
      send_item(MODE_WRITE_A, 4'd0, 4'd0, 16'h8000);
      send_item(MODE_WRITE_A, 4'd0, 4'd1, 16'h8000);
      send_item(MODE_WRITE_A, 4'd1, 4'd0, 16'h7FFF);
      send_item(MODE_WRITE_A, 4'd1, 4'd1, 16'h7FFF);
      send_item(MODE_WRITE_B, 4'd0, 4'd0, 16'h8000);
      send_item(MODE_WRITE_B, 4'd1, 4'd0, 16'h8000);
      send_item(MODE_WRITE_B, 4'd0, 4'd1, 16'h7FFF);
      send_item(MODE_WRITE_B, 4'd1, 4'd1, 16'h7FFF);
      send_item(MODE_COMPUTE, 4'd0, 4'd0, 16'h0000);
      send_item(MODE_COMPUTE, 4'd0, 4'd1, 16'hFFFF);
      send_item(MODE_COMPUTE, 4'd1, 4'd0, 16'h0000);
      send_item(MODE_COMPUTE, 4'd1, 4'd1, 16'h0000);

      // Out-of-range indices for each kind: rejected, stores untouched
      send_item(MODE_WRITE_A, 4'd2, 4'd0, 16'h1234);
      send_item(MODE_WRITE_A, 4'd0, 4'd15, 16'h1234);
      send_item(MODE_WRITE_B, 4'd2, 4'd0, 16'h4321);
      send_item(MODE_WRITE_B, 4'd0, 4'd2, 16'h4321);
      send_item(MODE_COMPUTE, 4'd15, 4'd0, 16'h0000);
      send_item(MODE_COMPUTE, 4'd0, 4'd15, 16'h0000);
      send_item(MODE_UNUSED, 4'd0, 4'd0, 16'h0000);
      send_item(MODE_COMPUTE, 4'd0, 4'd0, 16'h0000);

      // Random part: first sender-light pacing, then swapped, then none
      for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
         if (phase == 4) begin
            send_idle = 63;
            recv_idle = 23;
         end else if (phase == 7) begin
            send_idle = 0;
            recv_idle = 0;
         end
         apply_sizes(rows_list[phase], inner_list[phase], cols_list[phase]);
         repeat (ITEMS_PER_SETTING) random_item();
      end

      // Drain, then allow a longest compute for any stray response
      req_tvalid <= 1'b0;
      while (model.pending() != 0) @(posedge clock);
      repeat (MAX_DIM + 8) @(posedge clock);
      if (model.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
`default_nettype wire

// File: matrix_multiply_dot_engine_top.f
rtl/core/mmde_pkg.sv
rtl/core/mmde_ram.sv
rtl/core/mmde_mac.sv
rtl/core/matrix_multiply_dot_engine_top.sv
sim/testbench.sv
